>>> src/water_ripple_stencil_unit_assert.svh
// Assertion macros for the checker file.
`ifndef WATER_RIPPLE_STENCIL_UNIT_ASSERT_SVH
`define WATER_RIPPLE_STENCIL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/wrs_pkg.sv
package wrs_pkg;

   // Field widths
   localparam int HEIGHT_W    = 16;
   localparam int SHADE_W     = 4;
   localparam int SHIFT_W     = 4;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   // Smallest frame dimension in use
   localparam int MIN_DIM = 3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING_SHIFT = 2'd2;

   // Register reset values
   localparam int FRAME_WIDTH_RESET  = 180;
   localparam int FRAME_HEIGHT_RESET = 95;
   localparam logic [SHIFT_W-1:0] DAMPING_SHIFT_RESET = 4'd13;

   typedef struct packed {
      logic [HEIGHT_W-1:0] current_height;
      logic [HEIGHT_W-1:0] older_height;
      logic                frame_start;
   } req_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] new_height;
      logic [SHADE_W-1:0]  shade_index;
      logic                border_cell;
      logic                frame_last;
   } rsp_type;

   // Per-cell info handed from the raster control to the height update
   typedef struct packed {
      logic                border;
      logic                last;
      logic                up_ok;
      logic                left_ok;
      logic [HEIGHT_W-1:0] down;
   } cell_info_type;

endpackage

>>> src/wrs_line_ram.sv
module wrs_line_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 513
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_W-1:0]        rd_data_a,
   output logic [DATA_W-1:0]        rd_data_b
);

   logic [DATA_W-1:0] line_mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // One write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= line_mem[rd_addr_a];
         rd_b_ff <= line_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/wrs_raster_ctrl.sv
module wrs_raster_ctrl #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  wrs_pkg::req_type                     req_data,
   output logic                                 req_stall,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       cfg_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]      cfg_height,
   input  logic [$clog2(2*MAX_WIDTH+1)-1:0]     off_up,
   input  logic [$clog2(2*MAX_WIDTH+1)-1:0]     off_left,
   input  logic [$clog2(2*MAX_WIDTH+1)-1:0]     off_right,
   input  logic [$clog2(2*MAX_WIDTH+1)-1:0]     off_old,
   input  logic                                 s1_ready,
   output logic                                 s1_valid,
   output wrs_pkg::cell_info_type               s1_info,
   output logic                                 ram_wr_en,
   output logic [$clog2(2*MAX_WIDTH+1)-1:0]     ram_wr_addr,
   output logic [$clog2(2*MAX_WIDTH+1)-1:0]     rd_up_addr,
   output logic [$clog2(2*MAX_WIDTH+1)-1:0]     rd_left_addr,
   output logic [$clog2(2*MAX_WIDTH+1)-1:0]     rd_right_addr,
   output logic [$clog2(2*MAX_WIDTH+1)-1:0]     rd_old_addr
);

   localparam int CUR_SIZE = 2 * MAX_WIDTH + 1;
   localparam int AW = $clog2(CUR_SIZE);
   localparam int FW = $clog2(CUR_SIZE + 1);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // Ring address: base plus an offset below the ring size
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AW+1)'(CUR_SIZE)) begin
         sum = sum - (AW+1)'(CUR_SIZE);
      end
      ring_add = sum[AW-1:0];
   endfunction

   logic [CW-1:0] col_ff, col_in, c_cur, ocol, w_last;
   logic [RW-1:0] row_ff, row_in, r_cur, orow, h_last, h_last2;
   logic [AW-1:0] wp_ff, wp_in;
   logic [FW-1:0] cnt_ff, cnt_in, width_ext;
   logic [WW-1:0] col_next;
   logic [HW-1:0] row_next;
   logic [wrs_pkg::HEIGHT_W-1:0] down_ff;
   logic          s1_valid_ff;
   wrs_pkg::cell_info_type s1_info_ff, info_in;
   logic          accept, restart, emit, border, last;

   assign accept    = req_valid & s1_ready;
   assign req_stall = ~s1_ready;

   // Position of this request, restarted on frame start or out of range
   assign restart = req_data.frame_start || (HW'(row_ff) >= cfg_height) ||
                    (WW'(col_ff) >= cfg_width);
   assign c_cur   = restart ? '0 : col_ff;
   assign r_cur   = restart ? '0 : row_ff;
   assign w_last  = CW'(cfg_width - WW'(1));
   assign h_last  = RW'(cfg_height - HW'(1));
   assign h_last2 = RW'(cfg_height - HW'(2));

   // Emitted cell lies one row and one column behind
   always_comb begin
      if (c_cur != '0) begin
         ocol = c_cur - CW'(1);
         orow = (r_cur == '0) ? h_last : r_cur - RW'(1);
      end else begin
         ocol = w_last;
         if (r_cur >= RW'(2)) begin
            orow = r_cur - RW'(2);
         end else if (r_cur == RW'(1)) begin
            orow = h_last;
         end else begin
            orow = h_last2;
         end
      end
   end

   assign border = (orow == '0) || (orow == h_last) || (ocol == '0) || (ocol == w_last);
   assign last   = (orow == h_last) && (ocol == w_last);

   // Fill count decides what has been written since reset
   assign width_ext = FW'(cfg_width);
   assign emit      = cnt_ff >= width_ext + FW'(1);

   always_comb begin
      info_in.border  = border;
      info_in.last    = last;
      info_in.up_ok   = cnt_ff >= (width_ext << 1) + FW'(1);
      info_in.left_ok = cnt_ff >= width_ext + FW'(2);
      info_in.down    = down_ff;
   end

   // Next position, write pointer and fill count
   assign col_next = WW'(c_cur) + WW'(1);
   assign row_next = HW'(r_cur) + HW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      wp_in  = wp_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (col_next >= cfg_width) begin
            col_in = '0;
            row_in = (row_next >= cfg_height) ? '0 : RW'(row_next);
         end else begin
            col_in = CW'(col_next);
            row_in = r_cur;
         end
         wp_in = (wp_ff == AW'(CUR_SIZE - 1)) ? '0 : wp_ff + AW'(1);
         if (cnt_ff != FW'(CUR_SIZE)) begin
            cnt_in = cnt_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         wp_ff       <= '0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         wp_ff  <= wp_in;
         cnt_ff <= cnt_in;
         if (s1_ready) begin
            s1_valid_ff <= accept & emit;
         end
      end
   end

   // Payload: last height and cell info travel with the RAM read
   always_ff @(posedge clock) begin
      if (accept) begin
         down_ff    <= req_data.current_height;
         s1_info_ff <= info_in;
      end
   end

   // Reads trail the write pointer by W to 2W+1; at full width the up read
   // lands on the entry being written and returns its old contents
   assign ram_wr_en     = accept;
   assign ram_wr_addr   = wp_ff;
   assign rd_up_addr    = ring_add(wp_ff, off_up);
   assign rd_left_addr  = ring_add(wp_ff, off_left);
   assign rd_right_addr = ring_add(wp_ff, off_right);
   assign rd_old_addr   = ring_add(wp_ff, off_old);

   assign s1_valid = s1_valid_ff;
   assign s1_info  = s1_info_ff;

endmodule

>>> src/wrs_height_calc.sv
module wrs_height_calc (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 s1_valid,
   input  wrs_pkg::cell_info_type               s1_info,
   input  logic [wrs_pkg::HEIGHT_W-1:0]         up_raw,
   input  logic [wrs_pkg::HEIGHT_W-1:0]         left_raw,
   input  logic [wrs_pkg::HEIGHT_W-1:0]         right_raw,
   input  logic [wrs_pkg::HEIGHT_W-1:0]         older_raw,
   input  logic [wrs_pkg::SHIFT_W-1:0]          damping_shift,
   output logic                                 s1_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output wrs_pkg::rsp_type                     rsp_data
);

   localparam int HW = wrs_pkg::HEIGHT_W;

   logic [HW-1:0] up_val, left_val, s_val, v_in, d_val, res;
   logic [HW+1:0] sum;
   logic          s2_valid_ff, rsp_valid_ff;
   logic [HW-1:0] v_ff, older_ff;
   logic          border_ff, last_ff;
   wrs_pkg::rsp_type rsp_ff, rsp_in;
   logic          out_ready, s2_ready;

   // Per-stage ready so bubbles fill while the output waits
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;
   assign s2_ready  = ~s2_valid_ff | out_ready;
   assign s1_ready  = ~s1_valid | s2_ready;

   // Stage 1: neighbor sum halved, minus older height, floored at zero
   assign up_val   = s1_info.up_ok ? up_raw : '0;
   assign left_val = s1_info.left_ok ? left_raw : '0;
   assign sum = {2'b00, up_val} + {2'b00, s1_info.down} + {2'b00, left_val} +
                {2'b00, right_raw};
   assign s_val = sum[HW:1];
   assign v_in  = (s_val > older_raw) ? s_val - older_raw : '0;

   // Stage 2: damping, border cells keep the older height
   assign d_val = v_ff >> damping_shift;
   assign res   = border_ff ? older_ff : ((d_val < v_ff) ? v_ff - d_val : '0);

   always_comb begin
      rsp_in.new_height  = res;
      rsp_in.shade_index = res[HW-1 -: wrs_pkg::SHADE_W];
      rsp_in.border_cell = border_ff;
      rsp_in.frame_last  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= s1_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid) begin
         v_ff      <= v_in;
         older_ff  <= older_raw;
         border_ff <= s1_info.border;
         last_ff   <= s1_info.last;
      end
      if (out_ready && s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/water_ripple_stencil_unit.sv
// A result passes the RAM read and stage-1 registers, then the stage-2 and output registers;
// it belongs to the cell W+1 requests earlier (one row and one column behind).
// Throughput: one request per cycle while req_stall is low, bounded by the single write port of each line RAM.
// Reset (synchronous, active high) clears position, write pointer, fill count and pipeline
// valids, and loads register defaults; the line RAMs are not swept, the fill count masks
// entries not yet written, so requests are taken from the first cycle after reset.
module water_ripple_stencil_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  wrs_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output wrs_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_en,
   input  logic [wrs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wrs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CUR_SIZE = 2 * MAX_WIDTH + 1;
   localparam int AW = $clog2(CUR_SIZE);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int DW = wrs_pkg::HEIGHT_W;
   localparam int RESET_WIDTH  = (wrs_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                                 MAX_WIDTH : wrs_pkg::FRAME_WIDTH_RESET;
   localparam int RESET_HEIGHT = (wrs_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                                 MAX_HEIGHT : wrs_pkg::FRAME_HEIGHT_RESET;

   function automatic logic [WW-1:0] clamp_width(input logic [wrs_pkg::CSR_DATA_W-1:0] value);
      if (int'(value) < wrs_pkg::MIN_DIM) begin
         clamp_width = WW'(wrs_pkg::MIN_DIM);
      end else if (int'(value) > MAX_WIDTH) begin
         clamp_width = WW'(MAX_WIDTH);
      end else begin
         clamp_width = WW'(value);
      end
   endfunction

   function automatic logic [HW-1:0] clamp_height(input logic [wrs_pkg::CSR_DATA_W-1:0] value);
      if (int'(value) < wrs_pkg::MIN_DIM) begin
         clamp_height = HW'(wrs_pkg::MIN_DIM);
      end else if (int'(value) > MAX_HEIGHT) begin
         clamp_height = HW'(MAX_HEIGHT);
      end else begin
         clamp_height = HW'(value);
      end
   endfunction

   // Ring offset that reads an entry written delay requests ago
   function automatic logic [AW-1:0] back_offset(input int delay);
      back_offset = AW'(CUR_SIZE - delay);
   endfunction

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [wrs_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic [AW-1:0] off_up_ff, off_left_ff, off_right_ff, off_old_ff;
   logic [AW-1:0] off_up_in, off_left_in, off_right_in, off_old_in;

   // Register writes: dimensions stored clamped, ring offsets follow the width
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      shift_in  = shift_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            wrs_pkg::CSR_FRAME_WIDTH:   width_in  = clamp_width(csr_wdata);
            wrs_pkg::CSR_FRAME_HEIGHT:  height_in = clamp_height(csr_wdata);
            wrs_pkg::CSR_DAMPING_SHIFT: shift_in  = csr_wdata[wrs_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
      off_up_in    = back_offset(2 * int'(width_in) + 1);
      off_left_in  = back_offset(int'(width_in) + 2);
      off_right_in = back_offset(int'(width_in));
      off_old_in   = back_offset(int'(width_in) + 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WW'(RESET_WIDTH);
         height_ff    <= HW'(RESET_HEIGHT);
         shift_ff     <= wrs_pkg::DAMPING_SHIFT_RESET;
         off_up_ff    <= back_offset(2 * RESET_WIDTH + 1);
         off_left_ff  <= back_offset(RESET_WIDTH + 2);
         off_right_ff <= back_offset(RESET_WIDTH);
         off_old_ff   <= back_offset(RESET_WIDTH + 1);
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         shift_ff     <= shift_in;
         off_up_ff    <= off_up_in;
         off_left_ff  <= off_left_in;
         off_right_ff <= off_right_in;
         off_old_ff   <= off_old_in;
      end
   end

   logic                   s1_ready, s1_valid, ram_wr_en;
   wrs_pkg::cell_info_type s1_info;
   logic [AW-1:0]          ram_wr_addr, rd_up_addr, rd_left_addr, rd_right_addr, rd_old_addr;
   logic [DW-1:0]          up_raw, left_raw;
   logic [2*DW-1:0]        pair_right, pair_old;

   // Position tracking, fill count and RAM addressing
   wrs_raster_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .req_stall     (req_stall),
      .cfg_width     (width_ff),
      .cfg_height    (height_ff),
      .off_up        (off_up_ff),
      .off_left      (off_left_ff),
      .off_right     (off_right_ff),
      .off_old       (off_old_ff),
      .s1_ready      (s1_ready),
      .s1_valid      (s1_valid),
      .s1_info       (s1_info),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .rd_up_addr    (rd_up_addr),
      .rd_left_addr  (rd_left_addr),
      .rd_right_addr (rd_right_addr),
      .rd_old_addr   (rd_old_addr)
   );

   // Current heights: up and left neighbors
   wrs_line_ram #(
      .DATA_W (DW),
      .DEPTH  (CUR_SIZE)
   ) u_cur_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (req_data.current_height),
      .rd_en     (ram_wr_en),
      .rd_addr_a (rd_up_addr),
      .rd_addr_b (rd_left_addr),
      .rd_data_a (up_raw),
      .rd_data_b (left_raw)
   );

   // Current and older heights side by side: right neighbor and older value
   wrs_line_ram #(
      .DATA_W (2 * DW),
      .DEPTH  (CUR_SIZE)
   ) u_pair_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   ({req_data.current_height, req_data.older_height}),
      .rd_en     (ram_wr_en),
      .rd_addr_a (rd_right_addr),
      .rd_addr_b (rd_old_addr),
      .rd_data_a (pair_right),
      .rd_data_b (pair_old)
   );

   // Stencil arithmetic and output register
   wrs_height_calc u_calc (
      .clock         (clock),
      .reset         (reset),
      .s1_valid      (s1_valid),
      .s1_info       (s1_info),
      .up_raw        (up_raw),
      .left_raw      (left_raw),
      .right_raw     (pair_right[2*DW-1:DW]),
      .older_raw     (pair_old[DW-1:0]),
      .damping_shift (shift_ff),
      .s1_ready      (s1_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

>>> src/wrs_checker.sv
`include "water_ripple_stencil_unit_assert.svh"

module wrs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wrs_pkg::rsp_type rsp_data
);

   // Shade index is the top nibble of the new height
   `WRS_ASSERT_SAME(a_shade_matches, clock, reset, rsp_valid, rsp_data.shade_index == rsp_data.new_height[15:12], "shade index does not match new height")

   // Last cell of a frame is always a corner, hence border
   `WRS_ASSERT_SAME(a_last_on_border, clock, reset, rsp_valid && rsp_data.frame_last, rsp_data.border_cell, "frame_last on a non-border cell")

   // With the output register empty the pipeline must take requests
   `WRS_ASSERT_SAME(a_free_when_empty, clock, reset, !rsp_valid, !req_stall, "request stalled with empty output")

   // A stalled result holds
   `WRS_ASSERT_NEXT(a_hold_stalled, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind water_ripple_stencil_unit wrs_checker u_wrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
